@@ src/gcdp_pkg.sv @@
package gcdp_pkg;

	localparam int ANGLE_FRAC_BITS = 23;
	localparam int ANGLE_SHIFT     = 32 - ANGLE_FRAC_BITS;
	localparam int STEPS           = 30;
	localparam int QSHIFT          = 30;
	localparam int TW              = 32;
	localparam int VW              = 36;
	localparam int ZW              = 34;

	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [VW-1:0] vcomp_t;
	typedef logic signed [ZW-1:0] zang_t;

	localparam logic [29:0] INV_GAIN      = 30'd652032874;
	localparam logic [28:0] DIST_TO_TURNS = 29'd460820986;
	localparam zang_t TURN_QUARTER = zang_t'(64'sd1073741824);
	localparam zang_t TURN_HALF    = zang_t'(64'sd2147483648);

	// Degrees to turns is a scale by 2^ANGLE_SHIFT / 360 = DEG_MUL / DEG_DIV.
	localparam int DEG_DIV             = 45;
	localparam int DEG_MUL             = (2 ** ANGLE_SHIFT) / 8;
	localparam int DEG_BIAS            = 180 / 8;
	localparam logic [32:0] DEG_RECIP  = 33'd6108397933;
	localparam int DEG_RECIP_SHIFT     = 38;
	localparam logic [12:0] FRAC_RECIP = 13'd5826;
	localparam int FRAC_SHIFT          = 18;

	localparam logic [29:0] ATAN_TURNS [STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

endpackage

@@ src/great_circle_destination_point.sv @@
// Destination point on a sphere of radius 6371 km from a start point, a distance
// and a bearing. Angles are degrees with 23 fraction bits, the heading unsigned,
// the rest signed; distance is in mm. The destination longitude is not wrapped.
// Both channels use valid and stall: a request is taken on a rising edge with
// in_valid high and in_stall low, a result on one with out_valid high and
// out_stall low.
// One request is taken every cycle while in_stall is low. The pipeline is three
// chains of 31 CORDIC stages (sine and cosine, then two atan2 passes) with nine
// arithmetic stages around them.
// The whole pipeline advances as one; it holds only while a finished result
// waits under out_stall, and in_stall is raised for exactly those cycles.
// Asynchronous reset clears every valid bit; payload registers are not reset.
module great_circle_destination_point (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] latitude_in,
	input  logic signed [31:0] longitude_in,
	input  logic [31:0]        distance_mm,
	input  logic [31:0]        heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [30:0] latitude_out,
	output logic signed [32:0] longitude_out
);
	import gcdp_pkg::*;

	localparam int CLAT = STEPS + 1;
	localparam int N    = 3 + CLAT + 3 + CLAT + 1 + CLAT + 2;
	localparam logic signed [30:0] POLE = 31'(90 * (2 ** ANGLE_FRAC_BITS));
	localparam logic signed [ZW+9:0] DEG360  = (ZW+10)'(360);
	localparam logic signed [ZW+9:0] DEG_RND = (ZW+10)'(2 ** (ANGLE_SHIFT - 1));

	function automatic logic [31:0] deg_turns(input logic [26:0] h, input logic [31:0] a,
		input logic neg);
		logic [5:0]  r;
		logic [11:0] u;
		logic [24:0] fp;
		logic [32:0] q;
		logic [31:0] t;
		r  = 6'(a - 32'(h) * 32'(DEG_DIV));
		u  = 12'(r) * 12'(DEG_MUL) + 12'(DEG_BIAS);
		fp = 25'(u) * 25'(FRAC_RECIP);
		q  = 33'(h) * 33'(DEG_MUL) + 33'(fp[FRAC_SHIFT +: 7]);
		t  = q[31:0];
		return neg ? -t : t;
	endfunction

	function automatic logic signed [ZW+9:0] to_deg(input zang_t t);
		logic signed [ZW+9:0] w;
		w = (ZW+10)'(t) * DEG360 + DEG_RND;
		return w >>> ANGLE_SHIFT;
	endfunction

	logic         adv;
	logic [N-1:0] vld_s;

	logic signed [30:0] lat_sat;
	logic [29:0]        lat_mag;
	logic [29:0]        lat_mag_s1;
	logic               lat_neg_s1;
	logic [31:0]        brg_s1;
	logic [31:0]        dist_s1;

	logic [64:0] lat_prod;
	logic [64:0] brg_prod;
	logic [60:0] dist_prod;
	logic [26:0] lat_h_s2;
	logic [26:0] brg_h_s2;
	logic [29:0] lat_mag_s2;
	logic        lat_neg_s2;
	logic [31:0] brg_s2;
	logic [31:0] dturn_s2;

	logic [31:0] lat_turn_s3;
	logic [31:0] brg_turn_s3;
	logic [31:0] dturn_s3;

	trig_t cl, sl, cd, sd, cb, sb;

	logic signed [TW+VW-1:0] p_sdcb, p_slcd, p_clcd, p_yc, p_slsdcb, p_clsdcb;
	vcomp_t sdcb_s4, slcd_s4, clcd_s4, yc_s4;
	trig_t  sl_s4, cl_s4;
	vcomp_t slsdcb_s5, clsdcb_s5, slcd_s5, clcd_s5, yc_s5;
	vcomp_t zc_s6, xc_s6, yc_s6;

	zang_t  dlon;
	vcomp_t mag1;
	logic signed [VW+30:0] hp;
	vcomp_t h_s7;

	zang_t  nlat;
	vcomp_t mag2;
	zang_t  nlat_c;
	logic signed [ZW+9:0] lat_deg;
	logic signed [ZW+9:0] dlon_deg;
	logic signed [30:0] lat_deg_s8;
	logic signed [32:0] dlon_deg_s8;
	logic signed [30:0] lat_s9;
	logic signed [32:0] lon_s9;

	logic signed [31:0] lon_s  [N-1];
	vcomp_t             zc_s   [CLAT+1];
	zang_t              dlon_s [CLAT+1];

	// The vector length of the second atan2 pass is not needed.
	logic unused_mag;

	assign in_stall  = vld_s[N-1] && out_stall;
	assign adv       = !in_stall;
	assign out_valid = vld_s[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	always_comb begin
		lat_sat = latitude_in;
		if (latitude_in > POLE) begin
			lat_sat = POLE;
		end
		if (latitude_in < -POLE) begin
			lat_sat = -POLE;
		end
		lat_mag = lat_sat[30] ? 30'(-lat_sat) : 30'(lat_sat);
	end

	assign lat_prod  = 65'(lat_mag_s1) * 65'(DEG_RECIP);
	assign brg_prod  = 65'(brg_s1) * 65'(DEG_RECIP);
	assign dist_prod = 61'(dist_s1) * 61'(DIST_TO_TURNS);

	always_ff @(posedge clk) begin
		if (adv) begin
			lat_mag_s1 <= lat_mag;
			lat_neg_s1 <= lat_sat[30];
			brg_s1     <= heading;
			dist_s1    <= distance_mm;

			lat_h_s2   <= lat_prod[DEG_RECIP_SHIFT +: 27];
			brg_h_s2   <= brg_prod[DEG_RECIP_SHIFT +: 27];
			lat_mag_s2 <= lat_mag_s1;
			lat_neg_s2 <= lat_neg_s1;
			brg_s2     <= brg_s1;
			dturn_s2   <= {3'b000, dist_prod[60:32]};

			lat_turn_s3 <= deg_turns(lat_h_s2, 32'(lat_mag_s2), lat_neg_s2);
			brg_turn_s3 <= deg_turns(brg_h_s2, brg_s2, 1'b0);
			dturn_s3    <= dturn_s2;
		end
	end

	gcdp_rot u_rot_lat (.clk(clk), .en(adv), .angle(lat_turn_s3), .cos_val(cl), .sin_val(sl));
	gcdp_rot u_rot_dist (.clk(clk), .en(adv), .angle(dturn_s3), .cos_val(cd), .sin_val(sd));
	gcdp_rot u_rot_brg (.clk(clk), .en(adv), .angle(brg_turn_s3), .cos_val(cb), .sin_val(sb));

	assign p_sdcb   = sd * cb;
	assign p_slcd   = sl * cd;
	assign p_clcd   = cl * cd;
	assign p_yc     = sd * sb;
	assign p_slsdcb = sl_s4 * sdcb_s4;
	assign p_clsdcb = cl_s4 * sdcb_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sdcb_s4 <= p_sdcb[QSHIFT +: VW];
			slcd_s4 <= p_slcd[QSHIFT +: VW];
			clcd_s4 <= p_clcd[QSHIFT +: VW];
			yc_s4   <= p_yc[QSHIFT +: VW];
			sl_s4   <= sl;
			cl_s4   <= cl;

			slsdcb_s5 <= p_slsdcb[QSHIFT +: VW];
			clsdcb_s5 <= p_clsdcb[QSHIFT +: VW];
			slcd_s5   <= slcd_s4;
			clcd_s5   <= clcd_s4;
			yc_s5     <= yc_s4;

			zc_s6 <= slcd_s5 + clsdcb_s5;
			xc_s6 <= clcd_s5 - slsdcb_s5;
			yc_s6 <= yc_s5;
		end
	end

	gcdp_vec u_vec_lon (.clk(clk), .en(adv), .x_in(xc_s6), .y_in(yc_s6), .angle(dlon),
		.mag(mag1));

	assign hp = mag1 * $signed({1'b0, INV_GAIN});

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s7 <= hp[QSHIFT +: VW];
		end
	end

	gcdp_vec u_vec_lat (.clk(clk), .en(adv), .x_in(h_s7), .y_in(zc_s[CLAT]), .angle(nlat),
		.mag(mag2));

	always_comb begin
		nlat_c = nlat;
		if (nlat > TURN_QUARTER) begin
			nlat_c = TURN_QUARTER;
		end
		if (nlat < -TURN_QUARTER) begin
			nlat_c = -TURN_QUARTER;
		end
		lat_deg  = to_deg(nlat_c);
		dlon_deg = to_deg(dlon_s[CLAT]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lon_s[0] <= longitude_in;
			for (int k = 1; k < N - 1; k++) begin
				lon_s[k] <= lon_s[k-1];
			end
			zc_s[0] <= zc_s6;
			for (int k = 1; k <= CLAT; k++) begin
				zc_s[k] <= zc_s[k-1];
			end
			dlon_s[0] <= dlon;
			for (int k = 1; k <= CLAT; k++) begin
				dlon_s[k] <= dlon_s[k-1];
			end

			lat_deg_s8  <= lat_deg[30:0];
			dlon_deg_s8 <= dlon_deg[32:0];

			lat_s9 <= lat_deg_s8;
			lon_s9 <= 33'(lon_s[N-2]) + dlon_deg_s8;
		end
	end

	assign latitude_out  = lat_s9;
	assign longitude_out = lon_s9;

	assign unused_mag = ^mag2;

endmodule

@@ src/gcdp_rot.sv @@
module gcdp_rot (
	input  logic            clk,
	input  logic            en,
	input  logic [31:0]     angle,
	output gcdp_pkg::trig_t cos_val,
	output gcdp_pkg::trig_t sin_val
);
	import gcdp_pkg::*;

	trig_t x_s [STEPS+1];
	trig_t y_s [STEPS+1];
	zang_t z_s [STEPS+1];
	logic  flip_s [STEPS+1];
	zang_t z0;
	logic  f0;

	always_comb begin
		z0 = zang_t'($signed(angle));
		f0 = 1'b0;
		if (z0 > TURN_QUARTER) begin
			z0 = z0 - TURN_HALF;
			f0 = 1'b1;
		end else if (z0 < -TURN_QUARTER) begin
			z0 = z0 + TURN_HALF;
			f0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= trig_t'(INV_GAIN);
			y_s[0]    <= '0;
			z_s[0]    <= z0;
			flip_s[0] <= f0;
			for (int i = 0; i < STEPS; i++) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - zang_t'(ATAN_TURNS[i]);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + zang_t'(ATAN_TURNS[i]);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	assign cos_val = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_val = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];

endmodule

@@ src/gcdp_vec.sv @@
module gcdp_vec (
	input  logic             clk,
	input  logic             en,
	input  gcdp_pkg::vcomp_t x_in,
	input  gcdp_pkg::vcomp_t y_in,
	output gcdp_pkg::zang_t  angle,
	output gcdp_pkg::vcomp_t mag
);
	import gcdp_pkg::*;

	vcomp_t x_s [STEPS+1];
	vcomp_t y_s [STEPS+1];
	zang_t  z_s [STEPS+1];
	logic   zero_s [STEPS+1];
	vcomp_t xf;
	vcomp_t yf;
	zang_t  zf;

	// Fold the vector into the right half plane.
	always_comb begin
		xf = x_in;
		yf = y_in;
		zf = '0;
		if (x_in[VW-1]) begin
			if (!y_in[VW-1]) begin
				xf = y_in;
				yf = -x_in;
				zf = TURN_QUARTER;
			end else begin
				xf = -y_in;
				yf = x_in;
				zf = -TURN_QUARTER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= xf;
			y_s[0]    <= yf;
			z_s[0]    <= zf;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			for (int i = 0; i < STEPS; i++) begin
				if (!y_s[i][VW-1] && (y_s[i] != '0)) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + zang_t'(ATAN_TURNS[i]);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - zang_t'(ATAN_TURNS[i]);
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	assign angle = zero_s[STEPS] ? '0 : z_s[STEPS];
	assign mag   = x_s[STEPS];

endmodule
